>>> hdl/hdlcd_pkg.sv
// shared constants and event codes for the hdlc byte-stuffing deframer
// no dependencies; used by the interfaces, the fcs fold and the top level
package hdlcd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned FCS_W     = 16;
  localparam int unsigned INDEX_CAP = 1024;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [FCS_W-1:0]   fcs_t;

  // event codes
  localparam kind_t EV_NONE     = 3'd0;
  localparam kind_t EV_DATA     = 3'd1;
  localparam kind_t EV_GOOD     = 3'd2;
  localparam kind_t EV_FCS_ERR  = 3'd3;
  localparam kind_t EV_OVERFLOW = 3'd4;

  localparam byte_t  FLAG_BYTE = 8'h7E;
  localparam byte_t  ESC_BYTE  = 8'h7D;
  localparam byte_t  ESC_XOR   = 8'h20;
  localparam count_t MIN_CLOSE = 11'd3;

  localparam fcs_t FCS_INIT = 16'hFFFF;
  localparam fcs_t FCS_GOOD = 16'hF0B8;
  localparam fcs_t FCS_POLY = 16'h8408;

endpackage

>>> hdl/hdlcd_if.sv
// valid/ready channel interfaces for the deframer: raw line bytes in, events out
// depends on hdlcd_pkg
interface hdlcd_byte_if;
  logic               valid;
  logic               ready;
  hdlcd_pkg::byte_t   line_byte;

  modport source (output valid, output line_byte, input ready);
  modport sink   (input valid, input line_byte, output ready);
endinterface

interface hdlcd_event_if;
  logic               valid;
  logic               ready;
  hdlcd_pkg::kind_t   event_kind;
  hdlcd_pkg::byte_t   data_byte;
  hdlcd_pkg::index_t  byte_index;
  hdlcd_pkg::index_t  payload_len;

  modport source (output valid, output event_kind, output data_byte,
                  output byte_index, output payload_len, input ready);
  modport sink   (input valid, input event_kind, input data_byte,
                  input byte_index, input payload_len, output ready);
endinterface

>>> hdl/hdlcd_fcs16.sv
// one-byte update of the reflected fcs-16 (poly 0x8408), purely combinational
// depends on hdlcd_pkg
module hdlcd_fcs16 (
  input  hdlcd_pkg::fcs_t  fcs_in,
  input  hdlcd_pkg::byte_t data_in,
  output hdlcd_pkg::fcs_t  fcs_out
);

  always_comb begin
    hdlcd_pkg::fcs_t acc;
    acc = fcs_in ^ {8'h00, data_in};
    for (int i = 0; i < 8; i++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ hdlcd_pkg::FCS_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    fcs_out = acc;
  end

endmodule

>>> hdl/hdlc_byte_stuff_deframer.sv
// HDLC async deframer: hunts for a 0x7E flag, removes 0x7D escapes (next byte
// XOR 0x20), emits each decoded byte with its index and checks the FCS-16
// (RFC 1662, residue 0xF0B8) at the closing flag. Every accepted line byte
// gives exactly one event beat. One byte is taken per clock while the output is
// not stalled: a byte is captured in an input register, decoded and folded into
// the FCS combinationally, and its event is loaded into the output register
// when the input register advances. A stalled event holds both registers, and
// once the input register is full the input stops accepting until the event is taken.
// The limit written through cfg_wr_data is clamped to MAX_FRAME and 1024 (0 acts
// as 1); when a data byte would bring the stored byte count to it the frame is
// dropped with an overflow event. Depends on hdlcd_pkg, hdlcd_if and hdlcd_fcs16.
module hdlc_byte_stuff_deframer #(
  parameter int unsigned MAX_FRAME = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  hdlcd_byte_if.sink              in_bus,
  hdlcd_event_if.source           out_bus,
  input  logic                    cfg_wr_en,
  input  hdlcd_pkg::count_t       cfg_wr_data
);

  localparam int unsigned CAP = (MAX_FRAME < hdlcd_pkg::INDEX_CAP) ?
                                MAX_FRAME : hdlcd_pkg::INDEX_CAP;
  localparam hdlcd_pkg::count_t CAP_C = hdlcd_pkg::COUNT_W'(CAP);

  // effective limit, clamped at write time
  hdlcd_pkg::count_t lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= CAP_C;
    end else if (cfg_wr_en) begin
      if (cfg_wr_data > CAP_C) begin
        lim_r <= CAP_C;
      end else if (cfg_wr_data == '0) begin
        lim_r <= hdlcd_pkg::COUNT_W'(1);
      end else begin
        lim_r <= cfg_wr_data;
      end
    end
  end

  // input register
  logic             s1_valid_r;
  hdlcd_pkg::byte_t s1_byte_r;
  logic             out_valid_r;
  logic             s1_adv;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s1_byte_r <= in_bus.line_byte;
    end
  end

  // frame state
  logic              in_frame_r, in_frame_nxt;
  logic              esc_r, esc_nxt;
  hdlcd_pkg::count_t count_r, count_nxt;
  hdlcd_pkg::fcs_t   fcs_r, fcs_nxt;

  hdlcd_pkg::byte_t  dec_byte;
  hdlcd_pkg::fcs_t   fcs_fold;
  hdlcd_pkg::count_t count_inc;

  hdlcd_pkg::kind_t  kind_nxt;
  hdlcd_pkg::byte_t  data_nxt;
  hdlcd_pkg::index_t idx_nxt;
  hdlcd_pkg::index_t plen_nxt;

  assign dec_byte  = esc_r ? (s1_byte_r ^ hdlcd_pkg::ESC_XOR) : s1_byte_r;
  assign count_inc = count_r + hdlcd_pkg::COUNT_W'(1);

  hdlcd_fcs16 u_fcs (
    .fcs_in  (fcs_r),
    .data_in (dec_byte),
    .fcs_out (fcs_fold)
  );

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    count_nxt    = count_r;
    fcs_nxt      = fcs_r;
    kind_nxt     = hdlcd_pkg::EV_NONE;
    data_nxt     = '0;
    idx_nxt      = '0;
    plen_nxt     = '0;
    priority if (!in_frame_r) begin
      if (s1_byte_r == hdlcd_pkg::FLAG_BYTE) begin
        in_frame_nxt = 1'b1;
      end
    end else if (s1_byte_r == hdlcd_pkg::FLAG_BYTE) begin
      // short frames ignore the flag and keep everything
      if (count_r >= hdlcd_pkg::MIN_CLOSE) begin
        if (fcs_r == hdlcd_pkg::FCS_GOOD) begin
          kind_nxt = hdlcd_pkg::EV_GOOD;
          plen_nxt = hdlcd_pkg::INDEX_W'(count_r - hdlcd_pkg::COUNT_W'(2));
        end else begin
          kind_nxt = hdlcd_pkg::EV_FCS_ERR;
        end
        in_frame_nxt = 1'b0;
        esc_nxt      = 1'b0;
        count_nxt    = '0;
        fcs_nxt      = hdlcd_pkg::FCS_INIT;
      end
    end else if (s1_byte_r == hdlcd_pkg::ESC_BYTE) begin
      esc_nxt = 1'b1;
    end else begin
      if (count_inc >= lim_r) begin
        kind_nxt     = hdlcd_pkg::EV_OVERFLOW;
        in_frame_nxt = 1'b0;
        esc_nxt      = 1'b0;
        count_nxt    = '0;
        fcs_nxt      = hdlcd_pkg::FCS_INIT;
      end else begin
        kind_nxt  = hdlcd_pkg::EV_DATA;
        data_nxt  = dec_byte;
        idx_nxt   = count_r[hdlcd_pkg::INDEX_W-1:0];
        esc_nxt   = 1'b0;
        count_nxt = count_inc;
        fcs_nxt   = fcs_fold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      count_r    <= '0;
      fcs_r      <= hdlcd_pkg::FCS_INIT;
    end else if (s1_adv) begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      count_r    <= count_nxt;
      fcs_r      <= fcs_nxt;
    end
  end

  // result register
  hdlcd_pkg::kind_t  kind_r;
  hdlcd_pkg::byte_t  data_r;
  hdlcd_pkg::index_t idx_r;
  hdlcd_pkg::index_t plen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_bus.ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      kind_r <= kind_nxt;
      data_r <= data_nxt;
      idx_r  <= idx_nxt;
      plen_r <= plen_nxt;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.event_kind  = kind_r;
  assign out_bus.data_byte   = data_r;
  assign out_bus.byte_index  = idx_r;
  assign out_bus.payload_len = plen_r;

endmodule

>>> tb/tb_hdlc_byte_stuff_deframer.sv
`timescale 1ns / 1ps
// testbench for hdlc_byte_stuff_deframer: sends line bytes and stuffed frames,
// predicts every event beat and checks it field by field
// depends on hdlcd_pkg, hdlcd_if and the deframer rtl
module tb_hdlc_byte_stuff_deframer;

  localparam int unsigned FRAME_CAP    = 1024;
  localparam int          STALL_LIMIT  = 5000;
  localparam int          IDLE_PCT     = 17;
  localparam int          RANDOM_ITEMS = 420;

  typedef struct {
    hdlcd_pkg::kind_t  kind;
    hdlcd_pkg::byte_t  data;
    hdlcd_pkg::index_t idx;
    hdlcd_pkg::index_t plen;
  } deframe_ev_t;

  typedef hdlcd_pkg::byte_t byte_q_t[$];

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  hdlcd_pkg::count_t cfg_wr_data;

  hdlcd_byte_if  in_if();
  hdlcd_event_if out_if();

  hdlc_byte_stuff_deframer #(
    .MAX_FRAME(FRAME_CAP)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_if),
    .out_bus    (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // predicted deframer state
  bit                pr_in_frame;
  bit                pr_escape;
  hdlcd_pkg::count_t pr_count;
  hdlcd_pkg::fcs_t   pr_fcs;
  hdlcd_pkg::count_t pr_limit;

  deframe_ev_t pending_events[$];
  int          err_count;
  int          items_sent;
  int          idle_stall;
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic hdlcd_pkg::fcs_t fcs16_fold(hdlcd_pkg::fcs_t f, hdlcd_pkg::byte_t b);
    f = f ^ {8'h00, b};
    for (int i = 0; i < 8; i++) f = f[0] ? ((f >> 1) ^ hdlcd_pkg::FCS_POLY) : (f >> 1);
    return f;
  endfunction

  function automatic int unsigned frame_limit_eff();
    int unsigned lim;
    lim = pr_limit;
    if (lim > FRAME_CAP) lim = FRAME_CAP;
    if (lim > hdlcd_pkg::INDEX_CAP) lim = hdlcd_pkg::INDEX_CAP;
    if (lim == 0) lim = 1;
    return lim;
  endfunction

  function automatic void reset_deframe_state();
    pr_in_frame = 1'b0;
    pr_escape   = 1'b0;
    pr_count    = '0;
    pr_fcs      = hdlcd_pkg::FCS_INIT;
  endfunction

  function automatic deframe_ev_t deframe_step(hdlcd_pkg::byte_t b);
    deframe_ev_t      ev;
    hdlcd_pkg::byte_t d;
    ev.kind = hdlcd_pkg::EV_NONE;
    ev.data = '0;
    ev.idx  = '0;
    ev.plen = '0;
    if (!pr_in_frame) begin
      if (b == hdlcd_pkg::FLAG_BYTE) pr_in_frame = 1'b1;
    end else if (b == hdlcd_pkg::FLAG_BYTE) begin
      // flags before three stored bytes leave the frame untouched
      if (pr_count >= hdlcd_pkg::MIN_CLOSE) begin
        if (pr_fcs == hdlcd_pkg::FCS_GOOD) begin
          ev.kind = hdlcd_pkg::EV_GOOD;
          ev.plen = hdlcd_pkg::index_t'(pr_count - 11'd2);
        end else begin
          ev.kind = hdlcd_pkg::EV_FCS_ERR;
        end
        reset_deframe_state();
      end
    end else if (b == hdlcd_pkg::ESC_BYTE) begin
      pr_escape = 1'b1;
    end else begin
      d = pr_escape ? (b ^ hdlcd_pkg::ESC_XOR) : b;
      pr_escape = 1'b0;
      ev.idx = hdlcd_pkg::index_t'(pr_count);
      pr_fcs = fcs16_fold(pr_fcs, d);
      pr_count = pr_count + 11'd1;
      if (pr_count >= frame_limit_eff()) begin
        ev.kind = hdlcd_pkg::EV_OVERFLOW;
        ev.idx  = '0;
        reset_deframe_state();
      end else begin
        ev.kind = hdlcd_pkg::EV_DATA;
        ev.data = d;
      end
    end
    return ev;
  endfunction

  // result side: random backpressure, off during the no-idle stretch
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    deframe_ev_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_events.size() == 0) begin
        $error("event beat with nothing expected, event_kind %0d", out_if.event_kind);
        err_count++;
      end else begin
        want = pending_events.pop_front();
        if (out_if.event_kind !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, out_if.event_kind);
          err_count++;
        end
        if (out_if.data_byte !== want.data) begin
          $error("data_byte: expected %0h, got %0h", want.data, out_if.data_byte);
          err_count++;
        end
        if (out_if.byte_index !== want.idx) begin
          $error("byte_index: expected %0d, got %0d", want.idx, out_if.byte_index);
          err_count++;
        end
        if (out_if.payload_len !== want.plen) begin
          $error("payload_len: expected %0d, got %0d", want.plen, out_if.payload_len);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_stall = 0;
    end else begin
      idle_stall++;
      if (idle_stall >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_line_byte(input hdlcd_pkg::byte_t b);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.line_byte <= b;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pending_events.push_back(deframe_step(b));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frame_limit(input hdlcd_pkg::count_t v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pr_limit = v;
  endtask

  function automatic byte_q_t random_payload(int len);
    byte_q_t p;
    int      pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 4) p.push_back(hdlcd_pkg::FLAG_BYTE);
      else if (pick < 8) p.push_back(hdlcd_pkg::ESC_BYTE);
      else if (pick < 10) p.push_back(hdlcd_pkg::FLAG_BYTE ^ hdlcd_pkg::ESC_XOR);
      else p.push_back(hdlcd_pkg::byte_t'($urandom_range(255)));
    end
    return p;
  endfunction

  function automatic hdlcd_pkg::count_t random_limit();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return hdlcd_pkg::count_t'($urandom_range(40, 4));
    if (pick < 70) return hdlcd_pkg::count_t'($urandom_range(1024, 41));
    if (pick < 80) return hdlcd_pkg::count_t'($urandom_range(3));
    if (pick < 90) return hdlcd_pkg::count_t'($urandom_range(2047, 1025));
    return hdlcd_pkg::count_t'(FRAME_CAP);
  endfunction

  // opening flag, stuffed payload and fcs, optional closing flag
  task automatic send_frame(input hdlcd_pkg::byte_t payload[$], input bit corrupt,
                            input int esc_pct, input bit close_it);
    hdlcd_pkg::byte_t body[$];
    hdlcd_pkg::fcs_t  f;
    int               pos;
    body = payload;
    f = hdlcd_pkg::FCS_INIT;
    foreach (payload[i]) f = fcs16_fold(f, payload[i]);
    f = ~f;
    body.push_back(f[7:0]);
    body.push_back(f[15:8]);
    if (corrupt) begin
      pos = $urandom_range(body.size() - 1);
      body[pos] = body[pos] ^ hdlcd_pkg::byte_t'(8'h01 << $urandom_range(7));
    end
    send_line_byte(hdlcd_pkg::FLAG_BYTE);
    foreach (body[i]) begin
      // optional escapes must not turn into a flag or an escape on the line
      if (body[i] == hdlcd_pkg::FLAG_BYTE || body[i] == hdlcd_pkg::ESC_BYTE ||
          (body[i] != (hdlcd_pkg::FLAG_BYTE ^ hdlcd_pkg::ESC_XOR) &&
           body[i] != (hdlcd_pkg::ESC_BYTE ^ hdlcd_pkg::ESC_XOR) &&
           $urandom_range(99) < esc_pct)) begin
        send_line_byte(hdlcd_pkg::ESC_BYTE);
        send_line_byte(body[i] ^ hdlcd_pkg::ESC_XOR);
      end else begin
        send_line_byte(body[i]);
      end
    end
    if (close_it) send_line_byte(hdlcd_pkg::FLAG_BYTE);
  endtask

  task automatic test_directed_bytes();
    hdlcd_pkg::byte_t seq[$];
    hdlcd_pkg::byte_t p[$];
    // hunting noise, back-to-back flags, double escape, escape held across a
    // short flag, then a close with an escape pending
    seq = {8'h00, 8'hFF, hdlcd_pkg::ESC_BYTE, hdlcd_pkg::FLAG_BYTE, hdlcd_pkg::FLAG_BYTE,
           hdlcd_pkg::ESC_BYTE, hdlcd_pkg::ESC_BYTE,
           hdlcd_pkg::FLAG_BYTE ^ hdlcd_pkg::ESC_XOR, hdlcd_pkg::ESC_BYTE,
           hdlcd_pkg::FLAG_BYTE, hdlcd_pkg::ESC_BYTE ^ hdlcd_pkg::ESC_XOR, 8'hFF, 8'h00,
           hdlcd_pkg::ESC_BYTE, hdlcd_pkg::FLAG_BYTE};
    foreach (seq[i]) send_line_byte(seq[i]);
    p = {8'hA5};
    send_frame(p, 1'b0, 0, 1'b1);
  endtask

  task automatic test_frame_limits();
    hdlcd_pkg::count_t lims[$];
    lims = {11'd0, 11'd1, 11'd2, 11'd3, 11'd4, 11'd5};
    foreach (lims[i]) begin
      set_frame_limit(lims[i]);
      repeat (3) send_frame(random_payload($urandom_range(4, 1)), 1'b0, 40, 1'b1);
    end
  endtask

  task automatic test_long_frames();
    no_idle = 1'b1;
    set_frame_limit(11'h7FF);
    // largest good frame, with the written limit clamped to the cap
    send_frame(random_payload(FRAME_CAP - 3), 1'b0, 0, 1'b1);
    set_frame_limit(hdlcd_pkg::count_t'(FRAME_CAP));
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    int len;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = ($urandom_range(99) < 90) ? $urandom_range(24, 1) : $urandom_range(120, 25);
        if ($urandom_range(99) < 10) send_line_byte(hdlcd_pkg::FLAG_BYTE);
        send_frame(random_payload(len), $urandom_range(99) < 15, 10, 1'b1);
      end else if (pick < 82) begin
        repeat ($urandom_range(8, 1)) begin
          len = $urandom_range(99);
          if (len < 25) send_line_byte(hdlcd_pkg::FLAG_BYTE);
          else if (len < 40) send_line_byte(hdlcd_pkg::ESC_BYTE);
          else send_line_byte(hdlcd_pkg::byte_t'($urandom_range(255)));
        end
      end else if (pick < 92) begin
        // unterminated or escape-before-flag frames
        send_frame(random_payload($urandom_range(6)), $urandom_range(1), 10, 1'b0);
        if ($urandom_range(1)) begin
          send_line_byte(hdlcd_pkg::ESC_BYTE);
          send_line_byte(hdlcd_pkg::FLAG_BYTE);
        end
      end else if (pick < 96) begin
        set_frame_limit(random_limit());
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_if.valid     = 1'b0;
    in_if.line_byte = '0;
    no_idle         = 1'b0;
    err_count       = 0;
    items_sent      = 0;
    idle_stall      = 0;
    pr_limit        = hdlcd_pkg::count_t'(FRAME_CAP);
    reset_deframe_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_bytes();
    test_frame_limits();
    test_long_frames();
    test_random_traffic();

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0 && pending_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
